// ===== design/mh_pkg.sv =====
// Package for the magnetometer heading block: widths, configuration layout,
// pipeline payload types and the CORDIC arctangent table.
// No dependencies.
package mh_pkg;

   // Field and datapath widths
   localparam int RAW_W      = 16;
   localparam int COEF_W     = 16;
   localparam int ROW_W      = 48;
   localparam int PROD_W     = RAW_W + COEF_W;
   localparam int ACC_W      = PROD_W + 2;
   localparam int CAL_W      = 18;
   localparam int OFF_W      = 16;
   localparam int AX_W       = CAL_W + 1;
   localparam int HOFF_W     = 13;
   localparam int HEAD_W     = 12;
   localparam int CW         = 34;
   localparam int ZW         = 26;
   localparam int HW         = 31;
   localparam int Q16_SHIFT  = 16;

   // Arithmetic constants
   localparam int SCALE_SHIFT       = 12;
   localparam int GUARD_SHIFT       = 12;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_TABLE_LEN    = 24;
   localparam logic signed [ZW-1:0] HALF_TURN_Q16   = ZW'(180 * 65536);
   localparam logic signed [HW-1:0] FULL_TENTHS_Q16 = HW'(3600 * 65536);

   // Stream and register port widths
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_PAD_W  = RSP_DATA_W - HEAD_W - 3 * CAL_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = ROW_W;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW_X     = 3'd0,
      REG_ROW_Y     = 3'd1,
      REG_ROW_Z     = 3'd2,
      REG_OFFSET_X  = 3'd3,
      REG_OFFSET_Y  = 3'd4,
      REG_HEAD_OFF  = 3'd5,
      REG_FLIP      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [ROW_W-1:0]               row_x;
      logic [ROW_W-1:0]               row_y;
      logic [ROW_W-1:0]               row_z;
      logic signed [OFF_W-1:0]        off_x;
      logic signed [OFF_W-1:0]        off_y;
      logic signed [HOFF_W-1:0]       head_off;
      logic                           flip;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      row_x:    ROW_W'(4096),
      row_y:    ROW_W'(4096) << 16,
      row_z:    ROW_W'(4096) << 32,
      off_x:    '0,
      off_y:    '0,
      head_off: '0,
      flip:     1'b0
   };

   // Calibrated axes carried alongside the angle
   typedef struct packed {
      logic signed [CAL_W-1:0] x;
      logic signed [CAL_W-1:0] y;
      logic signed [CAL_W-1:0] z;
   } cal_type;

   // State handed from one CORDIC cell to the next
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      cal_type              cal;
   } cordic_type;

   // round(atan(2^-i) * 180/pi * 65536)
   function automatic logic signed [ZW-1:0] atan_q16(input int idx);
      logic signed [ZW-1:0] v;
      unique case (idx)
         0:       v = 26'sd2949120;
         1:       v = 26'sd1740967;
         2:       v = 26'sd919879;
         3:       v = 26'sd466945;
         4:       v = 26'sd234379;
         5:       v = 26'sd117304;
         6:       v = 26'sd58666;
         7:       v = 26'sd29335;
         8:       v = 26'sd14668;
         9:       v = 26'sd7334;
         10:      v = 26'sd3667;
         11:      v = 26'sd1833;
         12:      v = 26'sd917;
         13:      v = 26'sd458;
         14:      v = 26'sd229;
         15:      v = 26'sd115;
         16:      v = 26'sd57;
         17:      v = 26'sd29;
         18:      v = 26'sd14;
         19:      v = 26'sd7;
         20:      v = 26'sd4;
         21:      v = 26'sd2;
         22:      v = 26'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== design/mh_calib.sv =====
// Calibration front end: 3x3 matrix multiply, divide and saturate, then
// offset add and CORDIC start vector. Four pipeline stages.
// Depends on mh_pkg.
module mh_calib
   import mh_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic signed [RAW_W-1:0] raw_x,
   input  logic signed [RAW_W-1:0] raw_y,
   input  logic signed [RAW_W-1:0] raw_z,
   output logic                    out_valid,
   input  logic                    out_ready,
   output cordic_type              out_data
);

   localparam logic signed [ACC_W-1:0] DIV_BIAS = ACC_W'((1 << SCALE_SHIFT) - 1);
   localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'((1 << (CAL_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] SAT_MIN  = -ACC_W'(1 << (CAL_W - 1));

   logic [3:0] valid_ff;
   logic [3:0] adv;

   logic [ROW_W-1:0]        rows [3];
   logic signed [RAW_W-1:0] raws [3];

   logic signed [PROD_W-1:0] prod_in [3][3];
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [ACC_W-1:0]  acc_in  [3];
   logic signed [ACC_W-1:0]  acc_ff  [3];
   logic signed [CAL_W-1:0]  cal_in  [3];
   logic signed [CAL_W-1:0]  cal_ff  [3];
   cordic_type               out_in;
   cordic_type               out_ff;

   // Stage advance: a stage moves on when empty or when its successor takes it
   assign adv[3]   = !valid_ff[3] || out_ready;
   assign adv[2]   = !valid_ff[2] || adv[3];
   assign adv[1]   = !valid_ff[1] || adv[2];
   assign adv[0]   = !valid_ff[0] || adv[1];
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= in_valid;
         if (adv[1]) valid_ff[1] <= valid_ff[0];
         if (adv[2]) valid_ff[2] <= valid_ff[1];
         if (adv[3]) valid_ff[3] <= valid_ff[2];
      end
   end

   assign rows[0] = cfg.row_x;
   assign rows[1] = cfg.row_y;
   assign rows[2] = cfg.row_z;
   assign raws[0] = raw_x;
   assign raws[1] = raw_y;
   assign raws[2] = raw_z;

   // Stage 1: nine coefficient products
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = $signed(rows[r][COEF_W*c +: COEF_W]) * raws[c];
         end
      end
   end

   // Stage 2: row sums
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc_in[r] = ACC_W'(prod_ff[r][0]) + ACC_W'(prod_ff[r][1])
                   + ACC_W'(prod_ff[r][2]);
      end
   end

   // Stage 3: divide truncating toward zero, then saturate
   always_comb begin
      logic signed [ACC_W-1:0] biased;
      logic signed [ACC_W-1:0] quo;
      for (int r = 0; r < 3; r++) begin
         biased = acc_ff[r];
         if (acc_ff[r][ACC_W-1]) begin
            biased = acc_ff[r] + DIV_BIAS;
         end
         quo = biased >>> SCALE_SHIFT;
         if (quo > SAT_MAX) begin
            cal_in[r] = SAT_MAX[CAL_W-1:0];
         end else if (quo < SAT_MIN) begin
            cal_in[r] = SAT_MIN[CAL_W-1:0];
         end else begin
            cal_in[r] = quo[CAL_W-1:0];
         end
      end
   end

   // Stage 4: add offsets, fold the left half plane over by a half turn
   always_comb begin
      logic signed [AX_W-1:0] ax;
      logic signed [AX_W-1:0] ay;
      logic signed [CW-1:0]   xs;
      logic signed [CW-1:0]   ys;
      ax = AX_W'(cal_ff[0]) + AX_W'(cfg.off_x);
      ay = AX_W'(cal_ff[1]) + AX_W'(cfg.off_y);
      xs = CW'(ax) <<< GUARD_SHIFT;
      ys = CW'(ay) <<< GUARD_SHIFT;
      out_in.cal.x = cal_ff[0];
      out_in.cal.y = cal_ff[1];
      out_in.cal.z = cal_ff[2];
      if (ax[AX_W-1]) begin
         out_in.x = -xs;
         out_in.y = -ys;
         out_in.z = ay[AX_W-1] ? -HALF_TURN_Q16 : HALF_TURN_Q16;
      end else begin
         out_in.x = xs;
         out_in.y = ys;
         out_in.z = '0;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (adv[0]) prod_ff <= prod_in;
      if (adv[1]) acc_ff  <= acc_in;
      if (adv[2]) cal_ff  <= cal_in;
      if (adv[3]) out_ff  <= out_in;
   end

   assign out_valid = valid_ff[3];
   assign out_data  = out_ff;

endmodule

// ===== design/mh_cordic_cell.sv =====
// One vectoring CORDIC cell: rotates the vector toward the x axis by
// atan(2^-STAGE) and accumulates the angle. Depends on mh_pkg.
module mh_cordic_cell
   import mh_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  cordic_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output cordic_type out_data
);

   localparam logic signed [ZW-1:0] ANGLE = atan_q16(STAGE);

   logic       valid_ff;
   logic       adv;
   cordic_type data_in;
   cordic_type data_ff;

   assign adv      = !valid_ff || out_ready;
   assign in_ready = adv;

   // Rotate toward y = 0; a vector already on the axis passes unchanged
   always_comb begin
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      x  = in_data.x;
      y  = in_data.y;
      dx = y >>> STAGE;
      dy = x >>> STAGE;
      data_in = in_data;
      if (y != '0) begin
         if (!y[CW-1]) begin
            data_in.x = x + dx;
            data_in.y = y - dy;
            data_in.z = in_data.z + ANGLE;
         end else begin
            data_in.x = x - dx;
            data_in.y = y + dy;
            data_in.z = in_data.z - ANGLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== design/mh_post.sv =====
// Heading back end: sign flip, scale to Q16 tenths, heading offset, wrap and
// clamp to 0..3600, then the result register. Depends on mh_pkg.
module mh_post
   import mh_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  cordic_type              in_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [HEAD_W-1:0]       heading,
   output cal_type                 cal
);

   logic [1:0] valid_ff;
   logic [1:0] adv;

   logic signed [HW-1:0] h_in;
   logic signed [HW-1:0] h_ff;
   cal_type              cal_a_ff;
   logic [HEAD_W-1:0]    heading_in;
   logic [HEAD_W-1:0]    heading_ff;
   cal_type              cal_b_ff;

   assign adv[1]   = !valid_ff[1] || rsp_ready;
   assign adv[0]   = !valid_ff[0] || adv[1];
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= in_valid;
         if (adv[1]) valid_ff[1] <= valid_ff[0];
      end
   end

   // Flip, times ten as two shifts, plus the offset in Q16 tenths
   always_comb begin
      logic signed [ZW-1:0] a;
      logic signed [HW-1:0] aw;
      a    = cfg.flip ? -in_data.z : in_data.z;
      aw   = HW'(a);
      h_in = (aw <<< 3) + (aw <<< 1) + (HW'(cfg.head_off) <<< Q16_SHIFT);
   end

   // Wrap once, clamp what is still out of range, drop the fraction
   always_comb begin
      logic signed [HW-1:0] t;
      logic signed [HW-1:0] w;
      t = h_ff;
      if (h_ff[HW-1]) begin
         t = h_ff + FULL_TENTHS_Q16;
         w = t[HW-1] ? '0 : t;
      end else if (h_ff > FULL_TENTHS_Q16) begin
         t = h_ff - FULL_TENTHS_Q16;
         w = (t > FULL_TENTHS_Q16) ? FULL_TENTHS_Q16 : t;
      end else begin
         w = h_ff;
      end
      heading_in = w[Q16_SHIFT +: HEAD_W];
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         h_ff     <= h_in;
         cal_a_ff <= in_data.cal;
      end
      if (adv[1]) begin
         heading_ff <= heading_in;
         cal_b_ff   <= cal_a_ff;
      end
   end

   assign rsp_valid = valid_ff[1];
   assign heading   = heading_ff;
   assign cal       = cal_b_ff;

endmodule

// ===== design/magnetometer_heading_top.sv =====
// Magnetometer heading block, top level: configuration registers and the
// pipeline of calibration front end, CORDIC cell row and heading back end.
// Depends on mh_pkg, mh_calib, mh_cordic_cell and mh_post.
//
// Usage: send one raw three-axis sample per transfer on the req_ stream; one
// result (heading in tenths of a degree plus the three calibrated axes) comes
// back per sample on the rsp_ stream, in order.
// The pipeline has four calibration stages, one CORDIC cell per stage and
// two back-end stages. Throughput is one sample per cycle while rsp_tready
// is high; every stage is a register with its own valid bit, so bubbles
// close up and new samples are taken while a result waits.
// When rsp_tready is low the result register holds and the stages behind it
// fill up; req_tready falls only once every stage holds a sample.
// Configuration is written through csr_ (always ready), register index on
// csr_index, and must only change while no sample is in flight.
// Reset (synchronous) empties the pipeline and loads an identity matrix,
// zero offsets and no flip.
module magnetometer_heading_top
   import mh_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // tdata: raw_x [15:0], raw_y [31:16], raw_z [47:32]
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   // tdata: heading_tenths [11:0], cal_x [29:12], cal_y [47:30],
   //        cal_z [65:48], zero [71:66]
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   cfg_type cfg_ff;

   logic [CORDIC_STAGES:0] chain_valid;
   logic [CORDIC_STAGES:0] chain_ready;
   cordic_type             chain_data [CORDIC_STAGES+1];

   logic [HEAD_W-1:0]      heading;
   cal_type                cal;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            REG_ROW_X:    cfg_ff.row_x    <= csr_data[ROW_W-1:0];
            REG_ROW_Y:    cfg_ff.row_y    <= csr_data[ROW_W-1:0];
            REG_ROW_Z:    cfg_ff.row_z    <= csr_data[ROW_W-1:0];
            REG_OFFSET_X: cfg_ff.off_x    <= csr_data[OFF_W-1:0];
            REG_OFFSET_Y: cfg_ff.off_y    <= csr_data[OFF_W-1:0];
            REG_HEAD_OFF: cfg_ff.head_off <= csr_data[HOFF_W-1:0];
            REG_FLIP:     cfg_ff.flip     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Calibration front end
   mh_calib u_calib (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .raw_x     (req_tdata[RAW_W-1:0]),
      .raw_y     (req_tdata[2*RAW_W-1:RAW_W]),
      .raw_z     (req_tdata[3*RAW_W-1:2*RAW_W]),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   // Row of CORDIC cells
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      mh_cordic_cell #(
         .STAGE (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   // Heading back end and result register
   mh_post u_post (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (chain_valid[CORDIC_STAGES]),
      .in_ready  (chain_ready[CORDIC_STAGES]),
      .in_data   (chain_data[CORDIC_STAGES]),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .heading   (heading),
      .cal       (cal)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, cal.z, cal.y, cal.x, heading};

endmodule
